[rtl/core/crc32se_pkg.sv]
// crc32se_pkg: constants and the byte update function of the seeded crc-32 engine
// no dependencies; imported by the item and result interfaces and the engine
`timescale 1ns / 1ps
`default_nettype none

package crc32se_pkg;

	localparam int unsigned CrcWidth    = 32;
	localparam int unsigned ByteWidth   = 8;
	localparam int unsigned GroupPosW   = 3;

	// reflected form of 0x04c11db7
	localparam logic [CrcWidth-1:0]  CrcPolyReversed = 32'hEDB8_8320;
	// palette mode keeps group positions below this value
	localparam logic [GroupPosW-1:0] PaletteKeep     = 3'd2;

	typedef logic [CrcWidth-1:0]  crc_t;
	typedef logic [ByteWidth-1:0] byte_t;
	typedef logic [GroupPosW-1:0] grp_pos_t;

	// one reflected crc-32 byte update, shift-and-xor per bit
	function automatic crc_t crc_byte(input crc_t crc, input byte_t data);
		crc_t c;
		c = crc ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
		for (int k = 0; k < ByteWidth; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPolyReversed;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/crc32se_item_if.sv]
// crc32se_item_if: input channel of the engine, at most one message byte per transaction
// depends on crc32se_pkg
`timescale 1ns / 1ps
`default_nettype none

interface crc32se_item_if
	import crc32se_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  byte_present;
	logic  first_item;
	logic  last_item;
	crc_t  seed;

	modport source (
		output valid, data_byte, byte_present, first_item, last_item, seed,
		input  ready
	);
	modport sink (
		input  valid, data_byte, byte_present, first_item, last_item, seed,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/crc32se_result_if.sv]
// crc32se_result_if: result channel of the engine, one crc value per transaction
// depends on crc32se_pkg
`timescale 1ns / 1ps
`default_nettype none

interface crc32se_result_if
	import crc32se_pkg::*;
();
	logic valid;
	logic ready;
	crc_t crc_value;

	modport source (
		output valid, crc_value,
		input  ready
	);
	modport sink (
		input  valid, crc_value,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/crc32se_cfg_if.sv]
// crc32se_cfg_if: configuration write channel carrying the palette_mode bit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface crc32se_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/crc32_seeded_engine.sv]
// crc32_seeded_engine: seeded reflected crc-32, at most one byte per transaction
// depends on crc32se_pkg, crc32se_item_if, crc32se_result_if, crc32se_cfg_if
// result valid is registered from the input stage when it advances a last item
// throughput: one item per cycle unless s1 stalls behind a held result
// combinational xor byte update between the s1 stage and crc / result registers
// reset clears the running crc, saved seed, group position, palette mode and
// both valid flags; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module crc32_seeded_engine
	import crc32se_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	crc32se_item_if.sink    item,
	crc32se_result_if.source result,
	crc32se_cfg_if.sink     cfg
);

	// configuration register
	logic palette_mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_mode_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			palette_mode_q <= cfg.data;
		end
	end

	// input stage
	logic  valid_s1;
	byte_t data_byte_s1;
	logic  byte_present_s1;
	logic  first_item_s1;
	logic  last_item_s1;
	crc_t  seed_s1;

	// message state
	crc_t     running_crc_q;
	crc_t     saved_seed_q;
	grp_pos_t group_pos_q;

	// result register
	logic result_valid_q;
	crc_t result_crc_q;

	logic stall_s1;
	logic adv_s1;
	logic item_acc;

	// s1 only waits when it ends a message and the result register is still held
	assign stall_s1   = valid_s1 && last_item_s1 && result_valid_q && !result.ready;
	assign adv_s1     = valid_s1 && !stall_s1;
	assign item.ready = !stall_s1;
	assign item_acc   = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			data_byte_s1    <= item.data_byte;
			byte_present_s1 <= item.byte_present;
			first_item_s1   <= item.first_item;
			last_item_s1    <= item.last_item;
			seed_s1         <= item.seed;
		end
	end

	// byte update: seed load, then the byte, then the result
	crc_t     crc_start;
	crc_t     seed_eff;
	grp_pos_t pos_start;
	logic     take_byte;
	crc_t     crc_next;
	grp_pos_t pos_next;

	always_comb begin
		crc_start = first_item_s1 ? seed_s1 : running_crc_q;
		seed_eff  = first_item_s1 ? seed_s1 : saved_seed_q;
		pos_start = first_item_s1 ? '0 : group_pos_q;
		take_byte = byte_present_s1 && (!palette_mode_q || (pos_start < PaletteKeep));
		crc_next  = take_byte ? crc_byte(crc_start, data_byte_s1) : crc_start;
		pos_next  = byte_present_s1 ? pos_start + grp_pos_t'(1) : pos_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			saved_seed_q  <= '0;
			group_pos_q   <= '0;
		end else if (adv_s1) begin
			running_crc_q <= crc_next;
			saved_seed_q  <= seed_eff;
			group_pos_q   <= pos_next;
		end
	end

	// result register, reloads while the old value leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && last_item_s1) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_item_s1) begin
			result_crc_q <= crc_next ^ seed_eff;
		end
	end

	assign result.valid     = result_valid_q;
	assign result.crc_value = result_crc_q;

endmodule

`default_nettype wire
